// File: hw/rtl/tea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and constants of the triangle edge adjacency builder.
// ----------------------------------------------------------------------------
package tea_pkg;

	localparam int MAX_VERTICES  = 1024;
	localparam int MAX_TRIANGLES = 1024;
	localparam int MAX_EDGES     = 3 * MAX_TRIANGLES;

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int TW  = $clog2(MAX_TRIANGLES);
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int ECW = 12;
	localparam int TCW = 11;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  vertex_a;
		logic [9:0]  vertex_b;
		logic [9:0]  vertex_c;
		logic [11:0] edge_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] edge_count;
		logic [10:0] triangle_count;
		logic [9:0]  edge_low_vertex;
		logic [9:0]  edge_high_vertex;
		logic [9:0]  first_face;
		logic [9:0]  second_face;
		logic        boundary;
	} out_item_t;

	typedef struct packed {
		logic          vld;
		logic [EW-1:0] first;
		logic [EW-1:0] last;
	} head_t;

	typedef struct packed {
		logic          vld;
		logic [EW-1:0] nxt;
	} link_t;

	typedef struct packed {
		logic [9:0] lo;
		logic [9:0] hi;
		logic [9:0] f0;
		logic [9:0] f1;
	} edge_t;

endpackage

// File: hw/rtl/tea_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_in_if / tea_out_if
// Valid/ready channels carrying command and result transactions.
// ----------------------------------------------------------------------------
interface tea_in_if;
	logic               valid;
	logic               ready;
	tea_pkg::in_item_t  payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tea_out_if;
	logic               valid;
	logic               ready;
	tea_pkg::out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: hw/rtl/triangle_edge_adjacency_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_edge_adjacency_builder
// Edge list with face adjacency built from triangles, held in on-chip memories.
// ----------------------------------------------------------------------------
// One command transaction is taken at a time and answered by one result. An
// add checks each corner pair in turn, and each new edge reads and then writes
// the per-vertex head/tail memory. Finish visits each stored triangle and, for
// each pairing edge, walks the list entries in the edge memory. Clear, and the
// pass after reset, sweep the vertex head memory one entry per cycle, during
// which no command is taken; a clear answers once the sweep is done.
// ----------------------------------------------------------------------------
module triangle_edge_adjacency_builder (
	input  logic       clk,
	input  logic       arst_n,
	tea_in_if.sink     item,
	tea_out_if.source  result
);
	import tea_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_ADD_EDGE, S_ADD_WR, S_FIN_TRI, S_FIN_TRI_WAIT,
		S_FIN_EDGE, S_FIN_HEAD, S_FIN_WALK, S_RD_WAIT
	} state_t;

	head_t               head_mem [MAX_VERTICES];
	link_t               link_mem [MAX_EDGES];
	edge_t               edge_mem [MAX_EDGES];
	logic [3*VW-1:0]     tri_mem  [MAX_TRIANGLES];

	state_t              state_q;
	logic [1:0]          k_q;
	logic [TCW-1:0]      t_q;
	logic [VW-1:0]       v_q [3];
	logic [ECW-1:0]      e_total_q;
	logic [TCW-1:0]      t_total_q;
	logic                fin_q;
	logic [EW-1:0]       cur_q;
	logic [VW-1:0]       clr_q;
	logic                clr_rsp_q;
	logic                out_valid_q;
	out_item_t           out_q;

	head_t               head_rd;
	link_t               link_rd;
	edge_t               edge_rd;
	logic [3*VW-1:0]     tri_rd;

	logic                head_we;
	logic [VW-1:0]       head_wa, head_ra;
	head_t               head_wd;
	logic                link_we;
	logic [EW-1:0]       link_wa, link_ra;
	link_t               link_wd;
	logic                edge_we;
	logic [EW-1:0]       edge_wa, edge_ra;
	edge_t               edge_wd;
	logic                tri_we;

	logic                accept;
	logic [VW-1:0]       i1, i2;
	logic                add_ok;

	assign accept       = item.valid && item.ready;
	assign item.ready   = (state_q == S_IDLE) && !out_valid_q;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	assign i2 = v_q[k_q[1:0] == 2'd3 ? 2'd0 : k_q];
	assign i1 = (k_q == 2'd0) ? v_q[2] : v_q[k_q - 2'd1];

	assign add_ok = !fin_q && (t_total_q < TCW'(MAX_TRIANGLES))
		&& ({1'b0, item.payload.vertex_a} < (VW+1)'(MAX_VERTICES))
		&& ({1'b0, item.payload.vertex_b} < (VW+1)'(MAX_VERTICES))
		&& ({1'b0, item.payload.vertex_c} < (VW+1)'(MAX_VERTICES));

	always_comb begin
		head_we = 1'b0;
		head_wa = i1;
		head_wd = head_t'(0);
		head_ra = i1;
		link_we = 1'b0;
		link_wa = e_total_q[EW-1:0];
		link_wd = link_t'(0);
		link_ra = head_rd.first;
		edge_we = 1'b0;
		edge_wa = e_total_q[EW-1:0];
		edge_wd = '{lo: i1, hi: i2, f0: t_q[TW-1:0], f1: t_q[TW-1:0]};
		edge_ra = item.payload.edge_index[EW-1:0];
		tri_we  = 1'b0;
		case (state_q)
			S_IDLE: begin
				tri_we = accept && (item.payload.op == OP_ADD) && add_ok;
			end
			S_CLR: begin
				head_we = 1'b1;
				head_wa = clr_q;
			end
			S_ADD_EDGE: begin
				link_we = (k_q != 2'd3) && (i1 < i2);
			end
			S_ADD_WR: begin
				head_we = 1'b1;
				head_wd = '{vld: 1'b1,
					first: head_rd.vld ? head_rd.first : e_total_q[EW-1:0],
					last: e_total_q[EW-1:0]};
				link_we = head_rd.vld;
				link_wa = head_rd.last;
				link_wd = '{vld: 1'b1, nxt: e_total_q[EW-1:0]};
				edge_we = 1'b1;
			end
			S_FIN_EDGE: begin
				head_ra = i2;
			end
			S_FIN_HEAD: begin
				edge_ra = head_rd.first;
				link_ra = head_rd.first;
			end
			S_FIN_WALK: begin
				edge_ra = link_rd.nxt;
				link_ra = link_rd.nxt;
				edge_wa = cur_q;
				edge_wd = '{lo: edge_rd.lo, hi: edge_rd.hi, f0: edge_rd.f0,
					f1: t_q[TW-1:0]};
				edge_we = (edge_rd.hi == i1) && (edge_rd.f0 == edge_rd.f1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_rd <= link_mem[link_ra];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		edge_rd <= edge_mem[edge_ra];
	end

	always_ff @(posedge clk) begin
		if (tri_we) begin
			tri_mem[t_total_q[TW-1:0]] <= {item.payload.vertex_a, item.payload.vertex_b,
				item.payload.vertex_c};
		end
		tri_rd <= tri_mem[t_q[TW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			k_q         <= 2'd0;
			t_q         <= '0;
			e_total_q   <= '0;
			t_total_q   <= '0;
			fin_q       <= 1'b0;
			cur_q       <= '0;
			clr_q       <= '0;
			clr_rsp_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= out_item_t'(0);
			v_q         <= '{default: '0};
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.payload.op)
							OP_ADD: begin
								if (add_ok) begin
									v_q[0]    <= item.payload.vertex_a;
									v_q[1]    <= item.payload.vertex_b;
									v_q[2]    <= item.payload.vertex_c;
									k_q       <= 2'd0;
									t_q       <= t_total_q;
									t_total_q <= t_total_q + 1'b1;
									state_q   <= S_ADD_EDGE;
								end else begin
									out_q <= '{status: fin_q ? ST_DONE :
										(t_total_q >= TCW'(MAX_TRIANGLES)) ? ST_FULL : ST_RANGE,
										edge_count: e_total_q, triangle_count: t_total_q,
										default: '0};
									out_valid_q <= 1'b1;
								end
							end
							OP_FINISH: begin
								if (fin_q) begin
									out_q <= '{status: ST_DONE, edge_count: e_total_q,
										triangle_count: t_total_q, default: '0};
									out_valid_q <= 1'b1;
								end else begin
									t_q     <= '0;
									state_q <= S_FIN_TRI;
								end
							end
							OP_READ: begin
								if (item.payload.edge_index >= e_total_q
										|| item.payload.edge_index >= ECW'(MAX_EDGES)) begin
									out_q <= '{status: ST_RANGE, edge_count: e_total_q,
										triangle_count: t_total_q, default: '0};
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_RD_WAIT;
								end
							end
							default: begin
								e_total_q <= '0;
								t_total_q <= '0;
								fin_q     <= 1'b0;
								clr_q     <= '0;
								clr_rsp_q <= 1'b1;
								state_q   <= S_CLR;
							end
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VW'(MAX_VERTICES - 1)) begin
						if (clr_rsp_q) begin
							out_q       <= '{status: ST_OK, default: '0};
							out_valid_q <= 1'b1;
						end
						clr_rsp_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				S_ADD_EDGE: begin
					if (k_q == 2'd3) begin
						out_q       <= '{status: ST_OK, edge_count: e_total_q,
							triangle_count: t_total_q, default: '0};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (i1 < i2) begin
						state_q <= S_ADD_WR;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_ADD_WR: begin
					e_total_q <= e_total_q + 1'b1;
					k_q       <= k_q + 1'b1;
					state_q   <= S_ADD_EDGE;
				end
				S_FIN_TRI: begin
					if (t_q >= t_total_q) begin
						fin_q       <= 1'b1;
						out_q       <= '{status: ST_OK, edge_count: e_total_q,
							triangle_count: t_total_q, default: '0};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_FIN_TRI_WAIT;
					end
				end
				S_FIN_TRI_WAIT: begin
					v_q[0]  <= tri_rd[3*VW-1:2*VW];
					v_q[1]  <= tri_rd[2*VW-1:VW];
					v_q[2]  <= tri_rd[VW-1:0];
					k_q     <= 2'd0;
					state_q <= S_FIN_EDGE;
				end
				S_FIN_EDGE: begin
					if (k_q == 2'd3) begin
						t_q     <= t_q + 1'b1;
						state_q <= S_FIN_TRI;
					end else if (i1 > i2) begin
						state_q <= S_FIN_HEAD;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_FIN_HEAD: begin
					if (head_rd.vld) begin
						cur_q   <= head_rd.first;
						state_q <= S_FIN_WALK;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_FIN_EDGE;
					end
				end
				S_FIN_WALK: begin
					if (edge_we || !link_rd.vld) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_FIN_EDGE;
					end else begin
						cur_q <= link_rd.nxt;
					end
				end
				S_RD_WAIT: begin
					out_q <= '{status: ST_OK, edge_count: e_total_q,
						triangle_count: t_total_q,
						edge_low_vertex: edge_rd.lo, edge_high_vertex: edge_rd.hi,
						first_face: edge_rd.f0, second_face: edge_rd.f1,
						boundary: edge_rd.f0 == edge_rd.f1};
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == S_IDLE)
		else $error("result pending while busy");
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		e_total_q <= ECW'(MAX_EDGES))
		else $error("edge count overflow");
	a_tri_bound: assert property (@(posedge clk) disable iff (!arst_n)
		t_total_q <= TCW'(MAX_TRIANGLES))
		else $error("triangle count overflow");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD_WR |=> e_total_q == $past(e_total_q) + 1'b1)
		else $error("append did not advance edge count");
`endif

endmodule
